// ===== sv/pfd_pkg.sv =====
`default_nettype none

package pfd_pkg;

  // Command codes
  localparam logic [1:0] CMD_KEY  = 2'd0;
  localparam logic [1:0] CMD_SEAL = 2'd1;
  localparam logic [1:0] CMD_PAIR = 2'd2;

  localparam int unsigned SIDE    = 5;
  localparam int unsigned CELLS   = SIDE * SIDE;
  localparam int unsigned LETTERS = 26;

  localparam logic [4:0] IDX_NONE = 5'(LETTERS);
  localparam logic [4:0] IDX_I    = 5'd8;
  localparam logic [4:0] IDX_J    = 5'd9;
  localparam logic [4:0] IDX_LAST = 5'(LETTERS - 1);

  localparam logic [7:0] ASCII_UP_A = 8'h41;
  localparam logic [7:0] ASCII_UP_Z = 8'h5A;
  localparam logic [7:0] ASCII_LO_A = 8'h61;
  localparam logic [7:0] ASCII_LO_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP   = 8'd32;

  // J is always marked used
  localparam logic [LETTERS-1:0] USED_RESET = LETTERS'(1) << IDX_J;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEAL,
    ST_REREAD,
    ST_LOOKUP,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take;        // request accepted, latch cipher letters
    logic key_add;     // place key letter from input
    logic seal_start;  // restart fill walk
    logic seal_step;   // one letter of the fill walk
    logic pos_rd_in;   // position lookup from input letters
    logic pos_rd_lat;  // position lookup from latched letters
    logic cell_rd;     // square lookup of decrypted cells
    logic out_load;    // load result register
  } pfd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sealed;
    logic walk_last;
    logic out_free;
  } pfd_stat_t;

  // Letter index 0..25, or 26 for a non-letter
  function automatic logic [4:0] letter_index(input logic [7:0] ch);
    logic [7:0] c;
    c = ch;
    if (c >= ASCII_LO_A && c <= ASCII_LO_Z) c = c - CASE_GAP;
    if (c >= ASCII_UP_A && c <= ASCII_UP_Z) return 5'(c - ASCII_UP_A);
    return IDX_NONE;
  endfunction

  // Ciphertext letter: non-letter reads as A, J reads as I
  function automatic logic [4:0] cipher_index(input logic [7:0] ch);
    logic [4:0] li;
    li = letter_index(ch);
    if (li == IDX_NONE) return '0;
    if (li == IDX_J) return IDX_I;
    return li;
  endfunction

  function automatic logic [4:0] cell_addr(input logic [2:0] row, input logic [2:0] col);
    return 5'({row, 2'b00}) + 5'(row) + 5'(col);
  endfunction

  function automatic logic [2:0] dec_wrap(input logic [2:0] x);
    return (x == '0) ? 3'(SIDE - 1) : x - 3'd1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/playfair_decrypt.sv =====
`default_nettype none

// Playfair decryption over a 5x5 square with J folded into I. Requests carry
// a command: add key letter (cmd 0; case ignored, non-letters and J dropped,
// a key request after the square is sealed starts a new key), seal (cmd 1) or
// decrypt pair (cmd 2), which returns one result of two lowercase letters.
// Sealing walks the alphabet one letter per cycle through the fill logic;
// a pair that arrives on an unsealed square pays that walk plus a reread
// of its latched letters before its lookup. A pair on a sealed square runs
// through two registered table reads (letter to position, then position to
// cell) before its result is loaded into the result register; the next
// request is taken in the cycle the result loads. A finished pair whose
// result cannot load while out_stall_i holds the last one stalls new
// requests until that result drains.
module playfair_decrypt
  import pfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // request channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] key_char_i,
  input  wire logic [7:0] first_char_i,
  input  wire logic [7:0] second_char_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      plain_first_o,
  output logic [6:0]      plain_second_o
);

  pfd_cmd_t  ctrl_cmd;
  pfd_stat_t dp_stat;

  // sequencing: fill walk, lookup pipeline, result handoff
  pfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  // square storage, decrypt rule and result register
  pfd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .stat_o         (dp_stat),
    .key_char_i     (key_char_i),
    .first_char_i   (first_char_i),
    .second_char_i  (second_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .plain_first_o  (plain_first_o),
    .plain_second_o (plain_second_o)
  );

endmodule

`default_nettype wire

// ===== sv/pfd_ram.sv =====
`default_nettype none

module pfd_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 25
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic      [Width-1:0]         rdata_a_o,
  input  wire logic                     re_b_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_a_i) rdata_a_o <= mem_q[raddr_a_i];
    if (re_b_i) rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== sv/pfd_ctrl.sv =====
`default_nettype none

module pfd_ctrl
  import pfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] cmd_i,
  input  wire pfd_stat_t  stat_i,
  output pfd_cmd_t        cmd_o
);

  state_e state_q, state_d;
  logic   pend_q, pend_d;   // decrypt waiting on the fill walk
  logic   can_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    pend_d   = pend_q;
    cmd_o    = '0;
    can_take = (state_q == ST_IDLE) || (state_q == ST_EMIT && stat_i.out_free);

    unique case (state_q)
      ST_IDLE, ST_EMIT: begin
        if (state_q == ST_EMIT) begin
          if (stat_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end
        if (in_valid_i && can_take) begin
          cmd_o.take = 1'b1;
          unique case (cmd_i)
            CMD_KEY: begin
              cmd_o.key_add = 1'b1;
            end
            CMD_SEAL: begin
              if (!stat_i.sealed) begin
                cmd_o.seal_start = 1'b1;
                state_d          = ST_SEAL;
              end
            end
            CMD_PAIR: begin
              if (stat_i.sealed) begin
                cmd_o.pos_rd_in = 1'b1;
                state_d         = ST_LOOKUP;
              end else begin
                cmd_o.seal_start = 1'b1;
                pend_d           = 1'b1;
                state_d          = ST_SEAL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEAL: begin
        cmd_o.seal_step = 1'b1;
        if (stat_i.walk_last) begin
          state_d = pend_q ? ST_REREAD : ST_IDLE;
          pend_d  = 1'b0;
        end
      end
      ST_REREAD: begin
        cmd_o.pos_rd_lat = 1'b1;
        state_d          = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd_o.cell_rd = 1'b1;
        state_d       = ST_EMIT;
      end
      default: state_d = ST_IDLE;
    endcase

    in_stall_o = !can_take;
  end

endmodule

`default_nettype wire

// ===== sv/pfd_datapath.sv =====
`default_nettype none

module pfd_datapath
  import pfd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire pfd_cmd_t   cmd_i,
  output pfd_stat_t       stat_o,
  input  wire logic [7:0] key_char_i,
  input  wire logic [7:0] first_char_i,
  input  wire logic [7:0] second_char_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [6:0]      plain_first_o,
  output logic [6:0]      plain_second_o
);

  // table fill state
  logic [LETTERS-1:0] used_q, used_d, used_eff;
  logic [2:0]         row_q, row_d, col_q, col_d, row_eff, col_eff;
  logic               sealed_q, sealed_d;
  logic [4:0]         walk_q, walk_d;

  logic [4:0] src_idx;
  logic       clr, place;

  // latched cipher letters
  logic [4:0] first_idx_q, second_idx_q;

  // lookups
  logic [5:0] pos_a, pos_b;
  logic [4:0] cell_a, cell_b;
  logic [4:0] pos_raddr_a, pos_raddr_b;
  logic [2:0] r1, c1, r2, c2, o1r, o1c, o2r, o2c;

  logic       out_valid_q;
  logic [6:0] plain_first_q, plain_second_q;

  always_comb begin
    src_idx  = cmd_i.key_add ? letter_index(key_char_i) : walk_q;
    clr      = cmd_i.key_add && sealed_q;
    used_eff = clr ? USED_RESET : used_q;
    row_eff  = clr ? '0 : row_q;
    col_eff  = clr ? '0 : col_q;
    place    = (cmd_i.key_add || cmd_i.seal_step) && (src_idx < IDX_NONE) &&
               (row_eff != 3'(SIDE)) && !used_eff[src_idx];

    used_d   = used_eff;
    row_d    = row_eff;
    col_d    = col_eff;
    if (place) begin
      used_d[src_idx] = 1'b1;
      if (col_eff == 3'(SIDE - 1)) begin
        col_d = '0;
        row_d = row_eff + 3'd1;
      end else begin
        col_d = col_eff + 3'd1;
      end
    end

    sealed_d = sealed_q;
    if (cmd_i.key_add) sealed_d = 1'b0;
    if (cmd_i.seal_step && walk_q == IDX_LAST) sealed_d = 1'b1;

    walk_d = walk_q;
    if (cmd_i.seal_start) walk_d = '0;
    else if (cmd_i.seal_step) walk_d = walk_q + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= USED_RESET;
      row_q    <= '0;
      col_q    <= '0;
      sealed_q <= 1'b0;
      walk_q   <= '0;
    end else begin
      used_q   <= used_d;
      row_q    <= row_d;
      col_q    <= col_d;
      sealed_q <= sealed_d;
      walk_q   <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      first_idx_q  <= cipher_index(first_char_i);
      second_idx_q <= cipher_index(second_char_i);
    end
  end

  assign pos_raddr_a = cmd_i.pos_rd_in ? cipher_index(first_char_i)  : first_idx_q;
  assign pos_raddr_b = cmd_i.pos_rd_in ? cipher_index(second_char_i) : second_idx_q;

  // letter -> {row, col}
  pfd_ram #(
    .Width (6),
    .Depth (LETTERS)
  ) u_pos_ram (
    .clk_i     (clk_i),
    .we_i      (place),
    .waddr_i   (src_idx),
    .wdata_i   ({row_eff, col_eff}),
    .re_a_i    (cmd_i.pos_rd_in || cmd_i.pos_rd_lat),
    .raddr_a_i (pos_raddr_a),
    .rdata_a_o (pos_a),
    .re_b_i    (cmd_i.pos_rd_in || cmd_i.pos_rd_lat),
    .raddr_b_i (pos_raddr_b),
    .rdata_b_o (pos_b)
  );

  // decrypt rule on the two positions
  always_comb begin
    r1 = pos_a[5:3];
    c1 = pos_a[2:0];
    r2 = pos_b[5:3];
    c2 = pos_b[2:0];
    if (r1 == r2) begin
      o1r = r1; o1c = dec_wrap(c1);
      o2r = r2; o2c = dec_wrap(c2);
    end else if (c1 == c2) begin
      o1r = dec_wrap(r1); o1c = c1;
      o2r = dec_wrap(r2); o2c = c2;
    end else begin
      o1r = r1; o1c = c2;
      o2r = r2; o2c = c1;
    end
  end

  // cell -> letter
  pfd_ram #(
    .Width (5),
    .Depth (CELLS)
  ) u_cell_ram (
    .clk_i     (clk_i),
    .we_i      (place),
    .waddr_i   (cell_addr(row_eff, col_eff)),
    .wdata_i   (src_idx),
    .re_a_i    (cmd_i.cell_rd),
    .raddr_a_i (cell_addr(o1r, o1c)),
    .rdata_a_o (cell_a),
    .re_b_i    (cmd_i.cell_rd),
    .raddr_b_i (cell_addr(o2r, o2c)),
    .rdata_b_o (cell_b)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      plain_first_q  <= 7'(cell_a) + ASCII_LO_A[6:0];
      plain_second_q <= 7'(cell_b) + ASCII_LO_A[6:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign plain_first_o  = plain_first_q;
  assign plain_second_o = plain_second_q;

  assign stat_o.sealed    = sealed_q;
  assign stat_o.walk_last = (walk_q == IDX_LAST);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfd_pkg::*;

  // code 3 is not decoded by the block; it must be swallowed with no result
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned RANDOM_REQS = 1275;
  localparam int unsigned HOLD_CYCLES = 300;  // long receiver hold-off
  localparam int unsigned HOLD_AFTER  = 400;  // requests accepted before it starts
  localparam int unsigned TAIL_CYCLES = 64;   // quiet tail that watches for stray results
  localparam int unsigned DRAIN_LIMIT = 5000;

  // one request as queued for the driver; known = typed-in expected letters
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] key;
    logic [7:0] first;
    logic [7:0] second;
    bit         known;
    logic [7:0] want_first;
    logic [7:0] want_second;
  } pf_req_t;

  typedef struct packed {
    logic [6:0] first;
    logic [6:0] second;
  } plain_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_stall_o;
  logic [1:0] cmd_i          = CMD_KEY;
  logic [7:0] key_char_i     = 8'h00;
  logic [7:0] first_char_i   = 8'h00;
  logic [7:0] second_char_i  = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i    = 1'b0;
  logic [6:0] plain_first_o;
  logic [6:0] plain_second_o;

  playfair_decrypt u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .key_char_i     (key_char_i),
    .first_char_i   (first_char_i),
    .second_char_i  (second_char_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .plain_first_o  (plain_first_o),
    .plain_second_o (plain_second_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  pf_req_t     req_q[$];      // every request, directed rows first
  pf_req_t     dir_tab[25];
  plain_t      plain_q[$];    // plaintext pairs still owed by the block
  int unsigned acc_n  = 0;    // requests accepted so far
  int unsigned n_err  = 0;

  // ---------------------------------------------------------------------------
  // Square model: own copy of the 5x5 key square
  // ---------------------------------------------------------------------------
  bit          sq_used[LETTERS];
  logic [4:0]  sq_cell[CELLS];   // letter index held by each cell, row-major
  logic [4:0]  sq_pos[LETTERS];  // cell held by each letter
  int unsigned sq_fill;
  bit          sq_sealed;

  task automatic sq_clear();
    for (int i = 0; i < LETTERS; i++) begin
      sq_used[i] = (i == int'(IDX_J));  // J never gets a cell
      sq_pos[i]  = '0;
    end
    for (int i = 0; i < CELLS; i++) sq_cell[i] = '0;
    sq_fill   = 0;
    sq_sealed = 1'b0;
  endtask

  task automatic sq_place(input int unsigned li);
    if (li >= LETTERS || sq_used[li] || sq_fill >= CELLS) return;
    sq_used[li]      = 1'b1;
    sq_cell[sq_fill] = 5'(li);
    sq_pos[li]       = 5'(sq_fill);
    sq_fill++;
  endtask

  // append the unused letters A..Z in order
  task automatic sq_seal();
    if (sq_sealed) return;
    for (int unsigned li = 0; li < LETTERS; li++) sq_place(li);
    sq_sealed = 1'b1;
  endtask

  // 0..25, or LETTERS for anything that is not a letter
  function automatic int unsigned letter_of(input logic [7:0] ch);
    int unsigned c;
    c = int'(ch);
    if (c >= int'(ASCII_LO_A) && c <= int'(ASCII_LO_Z)) c = c - int'(CASE_GAP);
    if (c >= int'(ASCII_UP_A) && c <= int'(ASCII_UP_Z)) return c - int'(ASCII_UP_A);
    return LETTERS;
  endfunction

  // ciphertext: non-letter reads as A, J as I
  function automatic int unsigned cell_of(input logic [7:0] ch);
    int unsigned li;
    li = letter_of(ch);
    if (li == LETTERS) li = 0;
    if (li == int'(IDX_J)) li = int'(IDX_I);
    return int'(sq_pos[li]);
  endfunction

  task automatic decrypt_request(input logic [1:0] cmd, input logic [7:0] key,
                                 input logic [7:0] first, input logic [7:0] second,
                                 output bit got, output plain_t pt);
    int unsigned p1, p2, r1, c1, r2, c2, o1, o2;
    got = 1'b0;
    pt  = '0;
    case (cmd)
      CMD_KEY: begin
        if (sq_sealed) sq_clear();  // new key after a sealed square
        sq_place(letter_of(key));
      end
      CMD_SEAL: sq_seal();
      CMD_PAIR: begin
        sq_seal();                  // pair on an open square seals it first
        p1 = cell_of(first);
        p2 = cell_of(second);
        r1 = p1 / SIDE;
        c1 = p1 % SIDE;
        r2 = p2 / SIDE;
        c2 = p2 % SIDE;
        if (r1 == r2) begin         // same row: one column left
          o1 = r1 * SIDE + (c1 + SIDE - 1) % SIDE;
          o2 = r2 * SIDE + (c2 + SIDE - 1) % SIDE;
        end else if (c1 == c2) begin // same column: one row up
          o1 = ((r1 + SIDE - 1) % SIDE) * SIDE + c1;
          o2 = ((r2 + SIDE - 1) % SIDE) * SIDE + c2;
        end else begin              // rectangle: swap columns
          o1 = r1 * SIDE + c2;
          o2 = r2 * SIDE + c1;
        end
        pt.first  = 7'(int'(sq_cell[o1]) + int'(ASCII_LO_A));
        pt.second = 7'(int'(sq_cell[o2]) + int'(ASCII_LO_A));
        got = 1'b1;
      end
      default: ;                    // unused code: nothing
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic pf_req_t req_row(input logic [1:0] cmd, input logic [7:0] key,
                                      input logic [7:0] first, input logic [7:0] second,
                                      input bit known, input logic [7:0] wf,
                                      input logic [7:0] ws);
    pf_req_t r;
    r.cmd         = cmd;
    r.key         = key;
    r.first       = first;
    r.second      = second;
    r.known       = known;
    r.want_first  = wf;
    r.want_second = ws;
    return r;
  endfunction

  // append one request to the driver queue
  task automatic add_req(input pf_req_t r);
    req_q = {req_q, r};
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // a letter of random case with the given odds in percent, else any byte
  function automatic logic [7:0] rand_text(input int unsigned pct_letter);
    logic [7:0] c;
    if ($urandom_range(0, 99) >= pct_letter) return rand_byte();
    c = 8'(int'(ASCII_UP_A) + $urandom_range(0, LETTERS - 1));
    if ($urandom_range(0, 1) == 1) c = c + CASE_GAP;
    return c;
  endfunction

  // mostly well-formed sessions: key phrase, optional seal, run of pairs
  task automatic gen_random(input int unsigned n_reqs);
    int unsigned stop, scen, len, k, pos;
    logic [7:0]  perm[LETTERS];
    logic [7:0]  tmp;
    stop = req_q.size() + n_reqs;
    while (req_q.size() < stop) begin
      scen = $urandom_range(0, 9);
      if (scen == 9) begin
        // noise: any command, any bytes
        len = $urandom_range(1, 6);
        repeat (len) add_req(req_row(2'($urandom_range(0, 3)), rand_byte(),
                                     rand_byte(), rand_byte(), 1'b0, '0, '0));
      end else begin
        if (scen == 8) begin
          // whole alphabet shuffled: key alone fills all 25 cells
          for (k = 0; k < LETTERS; k++) perm[k] = 8'(int'(ASCII_UP_A) + k);
          for (k = LETTERS - 1; k > 0; k--) begin
            pos       = $urandom_range(0, k);
            tmp       = perm[k];
            perm[k]   = perm[pos];
            perm[pos] = tmp;
          end
          for (k = 0; k < LETTERS; k++) begin
            tmp = perm[k];
            if ($urandom_range(0, 1) == 1) tmp = tmp + CASE_GAP;
            add_req(req_row(CMD_KEY, tmp, rand_byte(), rand_byte(), 1'b0, '0, '0));
          end
        end else begin
          len = $urandom_range(1, 24);
          repeat (len) add_req(req_row(CMD_KEY, rand_text(85), rand_byte(),
                                       rand_byte(), 1'b0, '0, '0));
        end
        if ($urandom_range(0, 1) == 1)
          add_req(req_row(CMD_SEAL, rand_byte(), rand_byte(), rand_byte(),
                          1'b0, '0, '0));
        len = $urandom_range(1, 12);
        repeat (len) begin
          if ($urandom_range(0, 15) == 0)
            add_req(req_row(($urandom_range(0, 1) == 1) ? CMD_SEAL : CMD_UNUSED,
                            rand_byte(), rand_byte(), rand_byte(), 1'b0, '0, '0));
          add_req(req_row(CMD_PAIR, rand_byte(), rand_text(90), rand_text(90),
                          1'b0, '0, '0));
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    n_err++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitors. Both sample pre-edge values at the rising edge; all drivers use
  // nonblocking assignments so there is no ordering race.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_requests
    bit     got;
    plain_t pt;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      decrypt_request(cmd_i, key_char_i, first_char_i, second_char_i, got, pt);
      if (got) begin
        // directed rows with typed-in letters override the model
        if (req_q[acc_n].known)
          pt = {7'(req_q[acc_n].want_first), 7'(req_q[acc_n].want_second)};
        plain_q = {plain_q, pt};
      end
      acc_n++;
    end
  end

  always @(posedge clk_i) begin : watch_results
    plain_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (plain_q.size() == 0) begin
        report_mismatch($sformatf("result %h %h with no request pending",
                                  plain_first_o, plain_second_o));
      end else begin
        want = plain_q.pop_front();
        if (plain_first_o !== want.first)
          report_mismatch($sformatf("plain_first want %h got %h",
                                    want.first, plain_first_o));
        if (plain_second_o !== want.second)
          report_mismatch($sformatf("plain_second want %h got %h",
                                    want.second, plain_second_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: segments of random stall patterns, plus one long hold-off while
  // the sender keeps offering, so the result register backs up into in_stall_o.
  // ---------------------------------------------------------------------------
  initial begin : rx_pattern
    bit          held_off;
    int unsigned mode, seg_len, cyc;
    held_off = 1'b0;
    cyc      = 0;
    @(posedge clk_i);
    forever begin
      if (!held_off && acc_n >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(8, 64);
      repeat (seg_len) begin
        case (mode)
          0:       out_stall_i <= 1'b0;                          // free flowing
          1:       out_stall_i <= ($urandom_range(0, 1) == 1);   // coin flip
          2:       out_stall_i <= ($urandom_range(0, 9) < 7);    // mostly stalled
          default: out_stall_i <= ((cyc % 3) != 0);              // periodic
        endcase
        cyc++;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: directed table then random sessions, in bursts with random gaps.
  // ---------------------------------------------------------------------------
  initial begin : drive_requests
    int unsigned idx, burst, gap, t;
    sq_clear();

    // default square after reset: ABCDE / FGHIK / LMNOP / QRSTU / VWXYZ
    dir_tab = '{
      req_row(CMD_PAIR,   8'h00, "A",   "B",   1'b1, "e", "a"),  // same row, seals
      req_row(CMD_PAIR,   8'hFF, "A",   "F",   1'b1, "v", "a"),  // same column wrap
      req_row(CMD_PAIR,   8'h00, "J",   "Z",   1'b1, "k", "y"),  // J read as I
      req_row(CMD_PAIR,   8'hFF, 8'h00, 8'hFF, 1'b1, "e", "e"),  // non-letters read as A
      req_row(CMD_PAIR,   8'h00, "a",   "z",   1'b1, "e", "v"),  // rectangle, lowercase
      req_row(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00),
      req_row(CMD_SEAL,   8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00),  // already sealed
      req_row(CMD_KEY,    "p",   8'hFF, 8'h00, 1'b0, 8'h00, 8'h00),  // restarts the key
      req_row(CMD_KEY,    "L",   8'h00, 8'hFF, 1'b0, 8'h00, 8'h00),
      req_row(CMD_KEY,    "a",   8'h00, 8'h00, 1'b0, 8'h00, 8'h00),
      req_row(CMD_KEY,    "Y",   8'h00, 8'h00, 1'b0, 8'h00, 8'h00),
      req_row(CMD_KEY,    "1",   8'h00, 8'h00, 1'b0, 8'h00, 8'h00),  // non-letter dropped
      req_row(CMD_KEY,    "j",   8'h00, 8'h00, 1'b0, 8'h00, 8'h00),  // J dropped
      req_row(CMD_KEY,    "P",   8'h00, 8'h00, 1'b0, 8'h00, 8'h00),  // repeat dropped
      req_row(CMD_KEY,    8'hFF, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00),
      req_row(CMD_KEY,    8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00),
      req_row(CMD_KEY,    "F",   8'h00, 8'h00, 1'b0, 8'h00, 8'h00),
      req_row(CMD_KEY,    "e",   8'h00, 8'h00, 1'b0, 8'h00, 8'h00),
      req_row(CMD_SEAL,   8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00),
      req_row(CMD_PAIR,   8'h00, "B",   "M",   1'b0, 8'h00, 8'h00),
      req_row(CMD_PAIR,   8'h00, "J",   "j",   1'b0, 8'h00, 8'h00),  // doubled letter
      req_row(CMD_PAIR,   8'h00, "Z",   "z",   1'b0, 8'h00, 8'h00),
      req_row(CMD_KEY,    "Q",   8'h00, 8'h00, 1'b0, 8'h00, 8'h00),  // new key again
      req_row(CMD_PAIR,   8'h00, "x",   "?",   1'b0, 8'h00, 8'h00),  // pair seals it
      req_row(CMD_SEAL,   8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00)
    };
    foreach (dir_tab[i]) add_req(dir_tab[i]);
    gen_random(RANDOM_REQS);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    idx = 0;
    while (idx < req_q.size()) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && idx < req_q.size()) begin
        in_valid_i    <= 1'b1;
        cmd_i         <= req_q[idx].cmd;
        key_char_i    <= req_q[idx].key;
        first_char_i  <= req_q[idx].first;
        second_char_i <= req_q[idx].second;
        @(posedge clk_i);
        while (in_stall_o) @(posedge clk_i);
        idx++;
        burst--;
      end
      // a third of the bursts run straight into the next one
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    // let the last accept reach the model, drain, then watch for strays
    @(posedge clk_i);
    for (t = 0; t < DRAIN_LIMIT && plain_q.size() != 0; t++) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (plain_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", plain_q.size()));

    if (n_err == 0) begin
      $display("PASS playfair_decrypt");
    end else begin
      $display("FAIL playfair_decrypt");
    end
    $finish;
  end

  // hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #(20_000_000);
    $display("FAIL playfair_decrypt");
    $finish;
  end

endmodule
